// ----- rtl/rau_pkg.sv -----
// shared types and constants for the rational arithmetic unit
package rau_pkg;

  // default operand word width
  localparam int WORD_BITS_DEF = 32;

  // fixed widths of the result ports
  localparam int RES_NUM_BITS = 32;
  localparam int RES_DEN_BITS = 31;

  // operation codes
  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_MUL = 2'd1,
    KIND_NEG = 2'd2,
    KIND_RCP = 2'd3
  } kind_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_ZDEN = 2'd2
  } status_t;

  // back end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_COMB,
    BK_GCD,
    BK_DIV,
    BK_CHECK,
    BK_DONE
  } bk_state_t;

  // product being formed by the shared multiplier
  typedef enum logic [1:0] {
    MS_AN   = 2'd0,
    MS_ADBN = 2'd1,
    MS_DEN  = 2'd2
  } mul_step_t;

  // queue fill status
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- rtl/rau_front.sv -----
// front end: takes input words, splits operands into sign and magnitude
module rau_front
  import rau_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_kind,
  input  logic signed [31:0]            in_a_num,
  input  logic signed [31:0]            in_a_den,
  input  logic signed [31:0]            in_b_num,
  input  logic signed [31:0]            in_b_den,
  input  logic                          push_ready,
  output logic                          push_valid,
  output logic [3+4*(WORD_BITS+1)-1:0]  push_data
);

  localparam int QW = 3 + 4 * (WORD_BITS + 1);

  logic                 fr_valid_r, fr_valid_nxt;
  logic [QW-1:0]        fr_data_r, fr_data_nxt;
  logic                 accept;
  logic [WORD_BITS-1:0] an_raw, ad_raw, bn_raw, bd_raw;
  logic [WORD_BITS-1:0] an_mag, ad_mag, bn_mag, bd_mag;
  logic                 an_neg, ad_neg, bn_neg, bd_neg;
  logic                 direct;

  // low word bits of each field, sign and magnitude
  assign an_raw = in_a_num[WORD_BITS-1:0];
  assign ad_raw = in_a_den[WORD_BITS-1:0];
  assign bn_raw = in_b_num[WORD_BITS-1:0];
  assign bd_raw = in_b_den[WORD_BITS-1:0];
  assign an_neg = an_raw[WORD_BITS-1];
  assign ad_neg = ad_raw[WORD_BITS-1];
  assign bn_neg = bn_raw[WORD_BITS-1];
  assign bd_neg = bd_raw[WORD_BITS-1];
  assign an_mag = an_neg ? (~an_raw + 1'b1) : an_raw;
  assign ad_mag = ad_neg ? (~ad_raw + 1'b1) : ad_raw;
  assign bn_mag = bn_neg ? (~bn_raw + 1'b1) : bn_raw;
  assign bd_mag = bd_neg ? (~bd_raw + 1'b1) : bd_raw;

  // negate and reciprocal need no products
  assign direct = kind_t'(in_kind) inside {KIND_NEG, KIND_RCP};

  // hand-off stage
  assign in_stall   = fr_valid_r && !push_ready;
  assign accept     = in_valid && !in_stall;
  assign push_valid = fr_valid_r;
  assign push_data  = fr_data_r;

  always_comb begin
    fr_valid_nxt = accept || (fr_valid_r && !push_ready);
    fr_data_nxt  = fr_data_r;
    if (accept) begin
      fr_data_nxt = {in_kind, direct, an_neg, an_mag, ad_neg, ad_mag,
                     bn_neg, bn_mag, bd_neg, bd_mag};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
    fr_data_r <= fr_data_nxt;
  end

endmodule

// ----- rtl/rau_queue.sv -----
// two-entry queue between front end and back end
module rau_queue
  import rau_pkg::*;
#(
  parameter int DATA_BITS = 3 + 4 * (WORD_BITS_DEF + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [DATA_BITS-1:0] push_data,
  input  logic                 pop,
  output logic [DATA_BITS-1:0] pop_data,
  output q_stat_t              stat
);

  logic [DATA_BITS-1:0] mem_r [2];
  logic                 wr_ptr_r, wr_ptr_nxt;
  logic                 rd_ptr_r, rd_ptr_nxt;
  logic [1:0]           cnt_r, cnt_nxt;
  logic                 do_push, do_pop;

  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/rau_back.sv -----
// back end: products, sign fix, binary gcd, two dividers, range check
module rau_back
  import rau_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  q_stat_t                       q_stat,
  input  logic [3+4*(WORD_BITS+1)-1:0]  pop_data,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [RES_NUM_BITS-1:0] out_res_num,
  output logic [RES_DEN_BITS-1:0]       out_res_den,
  output logic [1:0]                    out_status
);

  localparam int W  = WORD_BITS;
  localparam int PW = 2 * WORD_BITS;
  localparam int CW = $clog2(PW);

  bk_state_t state_r, state_nxt;
  mul_step_t step_r;

  // unpacked queue entry
  logic [1:0]   q_kind;
  logic         q_direct;
  logic         q_an_neg, q_ad_neg, q_bn_neg, q_bd_neg;
  logic [W-1:0] q_an_mag, q_ad_mag, q_bn_mag, q_bd_mag;

  kind_t        kind_r;
  logic         an_neg_r, ad_neg_r, bn_neg_r, bd_neg_r;
  logic [W-1:0] an_mag_r, ad_mag_r, bn_mag_r, bd_mag_r;

  logic [PW-1:0] pa_r, pb_r, pd_r;
  logic [W-1:0]  mx, my;
  logic [PW-1:0] prod;

  logic [PW-1:0] cn_mag, cd_mag;
  logic          cn_neg, cd_neg;
  logic          sa_neg, sb_neg;

  logic [PW-1:0] n_r, d_r, u_r, v_r;
  logic          nneg_r;
  logic [PW-1:0] qn_r, qd_r, rn_r, rd_r;
  logic [CW-1:0] cnt_r;
  logic [PW:0]   rn_sh, rd_sh;
  logic          rn_ge, rd_ge;
  logic          gcd_end, div_end;

  logic [PW-1:0] half;
  logic          fin_neg, ovf;

  logic signed [RES_NUM_BITS-1:0] rs_num_r;
  logic [RES_DEN_BITS-1:0]        rs_den_r;
  status_t                        rs_status_r;
  logic                           out_valid_r;
  logic signed [RES_NUM_BITS-1:0] out_num_r;
  logic [RES_DEN_BITS-1:0]        out_den_r;
  status_t                        out_status_r;
  logic                           out_load;

  assign {q_kind, q_direct, q_an_neg, q_an_mag, q_ad_neg, q_ad_mag,
          q_bn_neg, q_bn_mag, q_bd_neg, q_bd_mag} = pop_data;

  // shared multiplier operand select
  always_comb begin
    case (step_r)
      MS_AN: begin
        mx = an_mag_r;
        my = (kind_r == KIND_MUL) ? bn_mag_r : bd_mag_r;
      end
      MS_ADBN: begin
        mx = ad_mag_r;
        my = bn_mag_r;
      end
      default: begin
        mx = ad_mag_r;
        my = bd_mag_r;
      end
    endcase
  end
  assign prod = mx * my;

  // raw numerator and denominator in sign and magnitude
  assign sa_neg = an_neg_r ^ bd_neg_r;
  assign sb_neg = ad_neg_r ^ bn_neg_r;
  always_comb begin
    cn_mag = pa_r;
    cn_neg = an_neg_r ^ bn_neg_r;
    cd_mag = pd_r;
    cd_neg = ad_neg_r ^ bd_neg_r;
    case (kind_r)
      KIND_ADD: begin
        if (sa_neg == sb_neg) begin
          cn_mag = pa_r + pb_r;
          cn_neg = sa_neg;
        end else if (pa_r >= pb_r) begin
          cn_mag = pa_r - pb_r;
          cn_neg = sa_neg;
        end else begin
          cn_mag = pb_r - pa_r;
          cn_neg = sb_neg;
        end
      end
      KIND_MUL: begin
        cn_mag = pa_r;
      end
      KIND_NEG: begin
        cn_mag = PW'(an_mag_r);
        cn_neg = !an_neg_r;
        cd_mag = PW'(ad_mag_r);
        cd_neg = ad_neg_r;
      end
      default: begin
        cn_mag = PW'(ad_mag_r);
        cn_neg = ad_neg_r;
        cd_mag = PW'(an_mag_r);
        cd_neg = an_neg_r;
      end
    endcase
  end

  // restoring divide step, both quotients side by side
  assign rn_sh = {rn_r, qn_r[PW-1]};
  assign rd_sh = {rd_r, qd_r[PW-1]};
  assign rn_ge = rn_sh >= {1'b0, v_r};
  assign rd_ge = rd_sh >= {1'b0, v_r};

  assign gcd_end = (u_r == '0);
  assign div_end = (cnt_r == CW'(PW - 1));

  // range check of the reduced fraction
  assign half    = PW'(1) << (W - 1);
  assign fin_neg = nneg_r && (qn_r != '0);
  assign ovf     = (qd_r > half - PW'(1)) ||
                   (fin_neg ? (qn_r > half) : (qn_r > half - PW'(1)));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          state_nxt = q_direct ? BK_COMB : BK_MUL;
        end
      end
      BK_MUL: begin
        if (step_r == MS_DEN) begin
          state_nxt = BK_COMB;
        end
      end
      BK_COMB: begin
        state_nxt = (cd_mag == '0) ? BK_DONE : BK_GCD;
      end
      BK_GCD: begin
        if (gcd_end) begin
          state_nxt = BK_DIV;
        end
      end
      BK_DIV: begin
        if (div_end) begin
          state_nxt = BK_CHECK;
        end
      end
      BK_CHECK: begin
        state_nxt = BK_DONE;
      end
      BK_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    pop      = (state_r == BK_IDLE) && !q_stat.empty;
    out_load = (state_r == BK_DONE) && (!out_valid_r || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        kind_r   <= kind_t'(q_kind);
        an_neg_r <= q_an_neg;
        ad_neg_r <= q_ad_neg;
        bn_neg_r <= q_bn_neg;
        bd_neg_r <= q_bd_neg;
        an_mag_r <= q_an_mag;
        ad_mag_r <= q_ad_mag;
        bn_mag_r <= q_bn_mag;
        bd_mag_r <= q_bd_mag;
        step_r   <= MS_AN;
      end
      BK_MUL: begin
        case (step_r)
          MS_AN: begin
            pa_r   <= prod;
            step_r <= (kind_r == KIND_ADD) ? MS_ADBN : MS_DEN;
          end
          MS_ADBN: begin
            pb_r   <= prod;
            step_r <= MS_DEN;
          end
          default: begin
            pd_r <= prod;
          end
        endcase
      end
      BK_COMB: begin
        n_r    <= cn_mag;
        d_r    <= cd_mag;
        u_r    <= cn_mag;
        v_r    <= cd_mag;
        nneg_r <= cn_neg ^ cd_neg;
        rs_num_r    <= '0;
        rs_den_r    <= '0;
        rs_status_r <= ST_ZDEN;
      end
      BK_GCD: begin
        if (gcd_end) begin
          qn_r  <= n_r;
          qd_r  <= d_r;
          rn_r  <= '0;
          rd_r  <= '0;
          cnt_r <= '0;
        end else if (!u_r[0] && !v_r[0]) begin
          // common factor of two comes out of both values
          u_r <= u_r >> 1;
          v_r <= v_r >> 1;
          n_r <= n_r >> 1;
          d_r <= d_r >> 1;
        end else if (!u_r[0]) begin
          u_r <= u_r >> 1;
        end else if (!v_r[0]) begin
          v_r <= v_r >> 1;
        end else if (u_r >= v_r) begin
          u_r <= u_r - v_r;
        end else begin
          v_r <= v_r - u_r;
        end
      end
      BK_DIV: begin
        rn_r  <= rn_ge ? PW'(rn_sh - {1'b0, v_r}) : rn_sh[PW-1:0];
        rd_r  <= rd_ge ? PW'(rd_sh - {1'b0, v_r}) : rd_sh[PW-1:0];
        qn_r  <= {qn_r[PW-2:0], rn_ge};
        qd_r  <= {qd_r[PW-2:0], rd_ge};
        cnt_r <= cnt_r + CW'(1);
      end
      BK_CHECK: begin
        if (ovf) begin
          rs_num_r    <= '0;
          rs_den_r    <= '0;
          rs_status_r <= ST_OVF;
        end else begin
          rs_num_r    <= fin_neg ? -RES_NUM_BITS'(qn_r) : RES_NUM_BITS'(qn_r);
          rs_den_r    <= RES_DEN_BITS'(qd_r);
          rs_status_r <= ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

  // output word register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_num_r    <= rs_num_r;
      out_den_r    <= rs_den_r;
      out_status_r <= rs_status_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_res_num = out_num_r;
  assign out_res_den = out_den_r;
  assign out_status  = out_status_r;

`ifndef SYNTHESIS
  // divisor is the nonzero gcd throughout the divide
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_DIV |-> v_r != '0)
    else $error("gcd divisor is zero");

  // a new result word only comes from the done state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == BK_DONE))
    else $error("result word without a finished item");

  // an ok result always has a positive denominator
  a_ok_den: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ST_OK |-> out_den_r != '0)
    else $error("ok result with zero denominator");

  // a taken entry starts the products or the direct path
  a_pop_next: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> state_r == BK_MUL || state_r == BK_COMB)
    else $error("entry taken without starting work");
`endif

endmodule

// ----- rtl/rational_arithmetic_unit.sv -----
// top level of the rational arithmetic unit
//
//  channel  direction  handshake          payload
//  in_      input      in_valid/in_stall   in_kind, in_a_num, in_a_den, in_b_num, in_b_den
//  out_     output     out_valid/out_stall out_res_num, out_res_den, out_status
//
// a back end word runs up to three products, a binary gcd of one shift or subtract
// per cycle and a 2*WORD_BITS-step restoring divide; a zero denominator skips the
// gcd and the divide and gives a zero-denominator status word.
// the front end and a two-entry queue take new words while the back end works.
// reset is synchronous, active low, and empties the queue and both handshakes.
// a stalled result word is held in the output register until taken.
module rational_arithmetic_unit
  import rau_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_kind,
  input  logic signed [31:0]             in_a_num,
  input  logic signed [31:0]             in_a_den,
  input  logic signed [31:0]             in_b_num,
  input  logic signed [31:0]             in_b_den,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [RES_NUM_BITS-1:0] out_res_num,
  output logic [RES_DEN_BITS-1:0]        out_res_den,
  output logic [1:0]                     out_status
);

  localparam int QW = 3 + 4 * (WORD_BITS + 1);

  logic          push_valid;
  logic [QW-1:0] push_data;
  logic [QW-1:0] pop_data;
  logic          pop;
  q_stat_t       q_stat;

  rau_front #(.WORD_BITS(WORD_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_kind    (in_kind),
    .in_a_num   (in_a_num),
    .in_a_den   (in_a_den),
    .in_b_num   (in_b_num),
    .in_b_den   (in_b_den),
    .push_ready (!q_stat.full),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  rau_queue #(.DATA_BITS(QW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  rau_back #(.WORD_BITS(WORD_BITS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_stat      (q_stat),
    .pop_data    (pop_data),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_res_num (out_res_num),
    .out_res_den (out_res_den),
    .out_status  (out_status)
  );

endmodule

// ----- test/testbench.sv -----
// self-checking testbench for the rational arithmetic unit
`timescale 1ns / 100ps

// scoreboard: predicts reduced fractions and checks result words in order
class rational_scoreboard;
  typedef struct {
    logic signed [31:0] num;
    logic [30:0]        den;
    rau_pkg::status_t   st;
  } fraction_t;

  fraction_t pending_q[$];
  int errors;
  int checked;
  int n_ovf;
  int n_zden;

  function automatic logic [63:0] euclid_gcd(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // note an accepted input word and store its expected result
  function void note_input(rau_pkg::kind_t k, logic signed [31:0] an,
                           logic signed [31:0] ad, logic signed [31:0] bn,
                           logic signed [31:0] bd);
    logic signed [127:0] num, den;
    logic [127:0] nmag, dmag, g;
    logic nneg;
    fraction_t f;
    case (k)
      rau_pkg::KIND_ADD: begin
        num = 128'(an) * 128'(bd) + 128'(ad) * 128'(bn);
        den = 128'(ad) * 128'(bd);
      end
      rau_pkg::KIND_MUL: begin
        num = 128'(an) * 128'(bn);
        den = 128'(ad) * 128'(bd);
      end
      rau_pkg::KIND_NEG: begin
        num = -128'(an);
        den = 128'(ad);
      end
      default: begin
        num = 128'(ad);
        den = 128'(an);
      end
    endcase
    f.num = 0;
    f.den = 0;
    if (den == 0) begin
      f.st = rau_pkg::ST_ZDEN;
    end else begin
      nneg = (num < 0) != (den < 0) && num != 0;
      nmag = num < 0 ? -num : num;
      dmag = den < 0 ? -den : den;
      g = euclid_gcd(nmag[63:0], dmag[63:0]);
      nmag = nmag / g;
      dmag = dmag / g;
      if (dmag > 128'h7fffffff || (nneg ? nmag > 128'h80000000 : nmag > 128'h7fffffff)) begin
        f.st = rau_pkg::ST_OVF;
      end else begin
        f.st = rau_pkg::ST_OK;
        f.num = nneg ? -nmag[31:0] : nmag[31:0];
        f.den = dmag[30:0];
      end
    end
    pending_q.push_back(f);
  endfunction

  function int pending();
    return pending_q.size();
  endfunction

  // compare a result word with the oldest expectation
  task check_result(logic signed [31:0] num, logic [30:0] den, logic [1:0] st);
    fraction_t f;
    checked++;
    if (pending_q.size() == 0) begin
      report("result word with nothing expected");
      return;
    end
    f = pending_q.pop_front();
    if (f.st == rau_pkg::ST_OVF) n_ovf++;
    if (f.st == rau_pkg::ST_ZDEN) n_zden++;
    if (st !== f.st) report($sformatf("status %0d, want %0d", st, f.st));
    if (num !== f.num) report($sformatf("res_num %0d, want %0d", num, f.num));
    if (den !== f.den) report($sformatf("res_den %0d, want %0d", den, f.den));
  endtask

  task report(string msg);
    errors++;
    if (errors <= 40) $display("error at %0t: %s", $realtime, msg);
  endtask
endclass

module testbench;
  import rau_pkg::*;

  localparam int LIMIT_CYCLES = 1500000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_kind = '0;
  logic signed [31:0] in_a_num = '0, in_a_den = '0, in_b_num = '0, in_b_den = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_res_num;
  logic [30:0] out_res_den;
  logic [1:0] out_status;

  rational_scoreboard board = new();
  int cycles = 0;
  int sent = 0;
  bit hold_off = 1'b0;

  always #2 clk = ~clk;

  rational_arithmetic_unit dut (.*);

  // cycle counter and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("rational_arithmetic_unit: mismatch");
      $finish;
    end
  end

  // note accepted inputs and check accepted results
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      board.note_input(kind_t'(in_kind), in_a_num, in_a_den, in_b_num, in_b_den);
      sent++;
    end
    if (rst_n && out_valid && !out_stall)
      board.check_result(out_res_num, out_res_den, out_status);
  end

  // receiver stall pattern, with a long hold-off on request
  initial begin
    int mode;
    forever begin
      @(posedge clk);
      mode = (cycles / 3000) % 3;
      if (hold_off) out_stall <= 1'b1;
      else if (mode == 0) out_stall <= 1'b0;
      else if (mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
      else out_stall <= ($urandom_range(0, 9) < 7);
    end
  end

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 20) - 10;
      1: return 32'sh7fffffff - $urandom_range(0, 2);
      2: return 32'sh80000000 + $urandom_range(0, 2);
      3: return $urandom_range(0, 2000) - 1000;
      4: return $signed(32'(($urandom_range(1, 60) * $urandom_range(1, 60))));
      default: return $urandom();
    endcase
  endfunction

  // offer one word and wait for acceptance
  task automatic send_word(kind_t k, logic signed [31:0] an, logic signed [31:0] ad,
                           logic signed [31:0] bn, logic signed [31:0] bd);
    in_valid <= 1'b1;
    in_kind <= k;
    in_a_num <= an;
    in_a_den <= ad;
    in_b_num <= bn;
    in_b_den <= bd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic idle_gap(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  initial begin
    int burst;
    kind_t k;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, every kind, zero denominator, zero numerator, overflow
    send_word(KIND_ADD, 1, 2, 1, 3);
    send_word(KIND_ADD, 1, 2, -1, 2);
    send_word(KIND_ADD, 32'sh7fffffff, 1, 32'sh7fffffff, 1);
    send_word(KIND_ADD, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_word(KIND_ADD, 1, 0, 1, 5);
    send_word(KIND_MUL, 6, -4, 10, 15);
    send_word(KIND_MUL, 32'sh80000000, 1, -1, 1);
    send_word(KIND_MUL, 32'sh80000000, -1, 1, -1);
    send_word(KIND_MUL, 0, 7, 5, -3);
    send_word(KIND_MUL, 3, 7, 5, 0);
    send_word(KIND_MUL, 32'sh7fffffff, 32'sh7fffffff, -1, 32'sh7fffffff);
    send_word(KIND_NEG, 32'sh80000000, 1, 0, 0);
    send_word(KIND_NEG, 32'sh80000000, -1, 0, 0);
    send_word(KIND_NEG, 4, -6, -1, -1);
    send_word(KIND_NEG, 5, 0, 1, 1);
    send_word(KIND_NEG, 0, -9, 1, 1);
    send_word(KIND_RCP, 0, 5, 1, 1);
    send_word(KIND_RCP, -3, 9, 1, 1);
    send_word(KIND_RCP, 1, 32'sh80000000, 1, 1);
    send_word(KIND_RCP, -1, 32'sh80000000, 1, 1);
    send_word(KIND_RCP, 32'shffffffff, 32'sh7fffffff, 32'sh7fffffff, 32'shffffffff);
    idle_gap(3);

    // random bursts; one stretch with the receiver held off
    while (sent < 520) begin
      if (sent > 150 && sent < 160 && !hold_off) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (3000) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        k = kind_t'($urandom_range(0, 3));
        send_word(k, rand_word(), rand_word(), rand_word(), rand_word());
      end
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 400));
    end
    in_valid <= 1'b0;

    while (board.pending() != 0 || hold_off) @(posedge clk);
    repeat (500) @(posedge clk);
    $display("covered %0d words, %0d results checked (%0d overflow, %0d zero denominator)",
             sent, board.checked, board.n_ovf, board.n_zden);
    if (board.errors == 0 && board.pending() == 0)
      $display("rational_arithmetic_unit: match");
    else
      $display("rational_arithmetic_unit: mismatch");
    $finish;
  end
endmodule
